/* rtl/core/okl_pkg.sv */
// ----------------------------------------------------------------------------
// okl_pkg
// shared types and codes for the ordered key list engine
// ----------------------------------------------------------------------------
package okl_pkg;

    localparam int KEY_W = 32;
    localparam int POS_W = 8;
    localparam int CNT_OUT_W = 9;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_REAR  = 3'd1;
    localparam logic [2:0] OP_FIND      = 3'd2;
    localparam logic [2:0] OP_POP_HEAD  = 3'd3;
    localparam logic [2:0] OP_REMOVE    = 3'd4;

    typedef struct packed {
        logic [2:0]              op;
        logic signed [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic                    ok;
        logic                    found;
        logic signed [KEY_W-1:0] key_out;
        logic [POS_W-1:0]        position;
        logic [CNT_OUT_W-1:0]    entry_count;
    } rsp_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_CLOSE,
        CELL_REAR
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t              mode;
        logic                    link_clr;
        logic                    search;
        logic signed [KEY_W-1:0] key;
        logic [CNT_OUT_W-1:0]    count;
    } cell_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] idx;
    } link_t;

endpackage

/* rtl/core/okl_cell.sv */
// ----------------------------------------------------------------------------
// okl_cell
// one list slot: holds a key, shifts with its neighbors, passes match link
// ----------------------------------------------------------------------------
module okl_cell
    import okl_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctl_t               ctl,
    input  logic signed [KEY_W-1:0] left_data,
    input  logic signed [KEY_W-1:0] right_data,
    input  link_t                   link_in,
    output link_t                   link_out,
    output logic signed [KEY_W-1:0] data
);

    logic signed [KEY_W-1:0] data_reg;
    logic signed [KEY_W-1:0] data_next;
    link_t                   link_reg;
    link_t                   link_next;
    logic                    occupied;
    logic                    match;

    assign occupied = (CNT_OUT_W'(INDEX) < ctl.count);
    assign match    = occupied && (data_reg == ctl.key);

    always_comb
    begin
        data_next = data_reg;
        case (ctl.mode)
            CELL_HOLD:  data_next = data_reg;
            CELL_PUSH:  data_next = left_data;
            CELL_POP:   data_next = right_data;
            CELL_CLOSE:
            begin
                if (link_in.hit || match)
                begin
                    data_next = right_data;
                end
            end
            CELL_REAR:
            begin
                if (CNT_OUT_W'(INDEX) == ctl.count)
                begin
                    data_next = ctl.key;
                end
            end
            default:    data_next = data_reg;
        endcase
    end

    always_comb
    begin
        link_next = link_reg;
        if (ctl.link_clr)
        begin
            link_next = '0;
        end
        else if (ctl.search)
        begin
            link_next.hit = link_in.hit || match;
            link_next.idx = link_in.hit ? link_in.idx : POS_W'(INDEX);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;
    assign data     = data_reg;

endmodule

/* rtl/core/okl_ctrl.sv */
// ----------------------------------------------------------------------------
// okl_ctrl
// request sequencer: entry count, search timing and response register
// ----------------------------------------------------------------------------
module okl_ctrl
    import okl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_ready,
    input  req_t                    req,
    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output rsp_t                    rsp,
    input  logic signed [KEY_W-1:0] head_data,
    input  link_t                   last_link,
    output cell_ctl_t               ctl
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    slot_free;
    logic                    req_fire;
    logic                    not_full;
    logic                    not_empty;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && slot_free;
    assign req_fire  = req_valid && req_ready;
    assign not_full  = (cnt_reg < CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        ctl.mode     = CELL_HOLD;
        ctl.link_clr = 1'b0;
        ctl.search   = 1'b0;
        ctl.key      = (state_reg == ST_IDLE) ? req.key : key_reg;
        ctl.count    = CNT_OUT_W'(cnt_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_next.ok       = 1'b0;
                    rsp_next.found    = 1'b0;
                    rsp_next.key_out  = req.key;
                    rsp_next.position = '0;
                    case (req.op)
                        OP_INS_FRONT:
                        begin
                            if (not_full)
                            begin
                                ctl.mode    = CELL_PUSH;
                                cnt_next    = cnt_reg + CNT_W'(1);
                                rsp_next.ok = 1'b1;
                            end
                            rsp_valid_next = 1'b1;
                        end
                        OP_INS_REAR:
                        begin
                            if (not_full)
                            begin
                                ctl.mode    = CELL_REAR;
                                cnt_next    = cnt_reg + CNT_W'(1);
                                rsp_next.ok = 1'b1;
                            end
                            rsp_valid_next = 1'b1;
                        end
                        OP_POP_HEAD:
                        begin
                            if (not_empty)
                            begin
                                ctl.mode         = CELL_POP;
                                cnt_next         = cnt_reg - CNT_W'(1);
                                rsp_next.ok      = 1'b1;
                                rsp_next.found   = 1'b1;
                                rsp_next.key_out = head_data;
                            end
                            rsp_valid_next = 1'b1;
                        end
                        OP_FIND, OP_REMOVE:
                        begin
                            ctl.link_clr = 1'b1;
                            op_next      = req.op;
                            key_next     = req.key;
                            step_next    = '0;
                            state_next   = ST_SEARCH;
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                    rsp_next.entry_count = CNT_OUT_W'(cnt_next);
                end
            end
            ST_SEARCH:
            begin
                ctl.search = 1'b1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DEPTH - 1))
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    if (last_link.hit && (op_reg == OP_REMOVE))
                    begin
                        ctl.mode = CELL_CLOSE;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    rsp_next.ok          = last_link.hit;
                    rsp_next.found       = last_link.hit;
                    rsp_next.key_out     = key_reg;
                    rsp_next.position    = last_link.hit ? last_link.idx : '0;
                    rsp_next.entry_count = CNT_OUT_W'(cnt_next);
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            op_reg        <= OP_FIND;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_search_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.op == OP_FIND || req.op == OP_REMOVE))
        |=> (state_reg == ST_SEARCH) && !req_ready && !rsp_valid_reg)
        else $error("search did not hold off requests");

    a_remove_lowers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && slot_free && last_link.hit && op_reg == OP_REMOVE)
        |=> (cnt_reg == $past(cnt_reg) - CNT_W'(1)) && rsp_valid_reg)
        else $error("remove by key did not lower the count");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !not_full && (req.op == OP_INS_FRONT || req.op == OP_INS_REAR))
        |=> $stable(cnt_reg) && !rsp_reg.ok)
        else $error("insert into full list changed the count");

endmodule

/* rtl/core/ordered_key_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_key_list_engine
// ordered key list in a chain of cells: insert front/rear, find, remove
// ----------------------------------------------------------------------------
//  channel  | signals                     | payload
//  request  | req_valid / req_ready       | req  (op, key)
//  response | rsp_valid / rsp_ready       | rsp  (ok, found, key_out, position, entry_count)
//
//  insert front, insert rear, remove head: applied on acceptance, back-to-back while responses drain
//  find, remove by key: the registered match link walks the chain cell by cell in ST_SEARCH
//  reset clears count, state and match links; cell keys stay undefined until written
//  a request is taken only while idle and the response register is free or draining
// ----------------------------------------------------------------------------
module ordered_key_list_engine
    import okl_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cell_ctl_t               ctl;
    logic signed [KEY_W-1:0] cell_data [DEPTH];
    link_t                   cell_link [DEPTH];

    okl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .head_data (cell_data[0]),
        .last_link (cell_link[DEPTH-1]),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [KEY_W-1:0] left_d;
        logic signed [KEY_W-1:0] right_d;
        link_t                   link_i;

        if (i == 0)
        begin : g_first
            assign left_d = ctl.key;
            assign link_i = '0;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
            assign link_i = cell_link[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_inner
            assign right_d = cell_data[i+1];
        end

        okl_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .left_data  (left_d),
            .right_data (right_d),
            .link_in    (link_i),
            .link_out   (cell_link[i]),
            .data       (cell_data[i])
        );
    end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench for the ordered key list engine
//
// Requests go in through a valid/ready sender and responses come out through a
// receiver, which add random gaps and stalls when idle_en is set. A behavioral
// copy of the list, kept as a queue, predicts every response. Each response is
// compared field by field with the oldest prediction. The directed tests cover
// the empty list, the full list, extreme keys, duplicate keys and the unused op
// codes. After them, random traffic pushes the list between empty and full.
// ----------------------------------------------------------------------------
module tb;
    import okl_pkg::*;

    localparam int LIST_DEPTH = 16;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    logic signed [KEY_W-1:0] key_list[$];
    rsp_t pending_rsp[$];
    bit idle_en = 1'b0;
    int stall_left = 0;
    int err_cnt = 0;
    int n_sent = 0;
    int n_checked = 0;
    int full_hits = 0;
    int empty_hits = 0;

    ordered_key_list_engine #(.DEPTH(LIST_DEPTH)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5000000;
        $display("tb NOT OK");
        $finish;
    end

    // expected response for one request; updates the list copy
    function automatic rsp_t list_apply(req_t r);
        rsp_t res;
        int idx;
        res = '0;
        res.key_out = r.key;
        idx = -1;
        foreach (key_list[i])
        begin
            if (idx < 0 && key_list[i] == r.key)
                idx = i;
        end
        case (r.op)
            OP_INS_FRONT:
            begin
                if (key_list.size() < LIST_DEPTH)
                begin
                    key_list.push_front(r.key);
                    res.ok = 1'b1;
                end
            end
            OP_INS_REAR:
            begin
                if (key_list.size() < LIST_DEPTH)
                begin
                    key_list.push_back(r.key);
                    res.ok = 1'b1;
                end
            end
            OP_FIND:
            begin
                if (idx >= 0)
                begin
                    res.ok = 1'b1;
                    res.found = 1'b1;
                    res.position = POS_W'(idx);
                end
            end
            OP_POP_HEAD:
            begin
                if (key_list.size() > 0)
                begin
                    res.key_out = key_list.pop_front();
                    res.ok = 1'b1;
                    res.found = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (idx >= 0)
                begin
                    key_list.delete(idx);
                    res.ok = 1'b1;
                    res.found = 1'b1;
                    res.position = POS_W'(idx);
                end
            end
            default:
            begin
            end
        endcase
        res.entry_count = CNT_OUT_W'(key_list.size());
        if (key_list.size() == LIST_DEPTH)
            full_hits++;
        if (key_list.size() == 0)
            empty_hits++;
        return res;
    endfunction

    task automatic send_req(input logic [2:0] op, input logic signed [KEY_W-1:0] key);
        req_t r;
        int gap;
        r.op = op;
        r.key = key;
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        pending_rsp.push_back(list_apply(r));
        n_sent++;
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (!idle_en)
        begin
            stall_left <= 0;
            rsp_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response transfer with no request outstanding");
                err_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("ok", longint'(want.ok), longint'(rsp.ok));
                check_field("found", longint'(want.found), longint'(rsp.found));
                check_field("key_out", longint'(want.key_out), longint'(rsp.key_out));
                check_field("position", longint'(want.position), longint'(rsp.position));
                check_field("entry_count", longint'(want.entry_count),
                            longint'(rsp.entry_count));
                n_checked++;
            end
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] pool[6];
        pool = '{32'sh8000_0000, 32'sh7fff_ffff, -32'sd1, 32'sd0, 32'sd1, 32'sh5a5a_5a5a};
        if ($urandom_range(0, 99) < 75)
            return pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    task automatic test_empty_list();
        send_req(OP_POP_HEAD, 32'sh8000_0000);
        send_req(OP_FIND, 32'sh7fff_ffff);
        send_req(OP_REMOVE, 32'sd0);
        send_req(OP_SPARE_LO, -32'sd1);
        send_req(OP_SPARE_HI, 32'sh7fff_ffff);
    endtask

    task automatic test_fill_and_overflow();
        send_req(OP_INS_REAR, 32'sh7fff_ffff);
        send_req(OP_INS_FRONT, 32'sh8000_0000);
        send_req(OP_INS_REAR, -32'sd1);
        send_req(OP_INS_REAR, 32'sd0);
        for (int i = 0; i < LIST_DEPTH - 6; i++)
            send_req(i[0] ? OP_INS_FRONT : OP_INS_REAR, 32'sd100 + i);
        send_req(OP_INS_REAR, -32'sd1);
        send_req(OP_INS_REAR, 32'sh5a5a_a5a5);
        send_req(OP_INS_FRONT, 32'sd7);
        send_req(OP_INS_REAR, 32'sd8);
    endtask

    task automatic test_search_and_remove();
        send_req(OP_FIND, -32'sd1);
        send_req(OP_FIND, 32'sh5a5a_a5a5);
        send_req(OP_FIND, 32'sd12345);
        send_req(OP_REMOVE, -32'sd1);
        send_req(OP_REMOVE, 32'sd12345);
        send_req(OP_POP_HEAD, 32'sd0);
    endtask

    task automatic test_random_traffic(input int count, input bit with_idle);
        bit grow;
        int r;
        logic [2:0] op;
        logic [2:0] spare_op;
        grow = 1'b1;
        idle_en = with_idle;
        for (int n = 0; n < count; n++)
        begin
            if (key_list.size() == LIST_DEPTH)
                grow = 1'b0;
            else if (key_list.size() == 0)
                grow = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                grow = !grow;
            r = $urandom_range(0, 99);
            spare_op = 3'($urandom_range(int'(OP_SPARE_LO), int'(OP_SPARE_HI)));
            if (grow)
                op = r < 30 ? OP_INS_FRONT : r < 60 ? OP_INS_REAR : r < 75 ? OP_FIND :
                     r < 83 ? OP_POP_HEAD : r < 96 ? OP_REMOVE : spare_op;
            else
                op = r < 10 ? OP_INS_FRONT : r < 20 ? OP_INS_REAR : r < 40 ? OP_FIND :
                     r < 65 ? OP_POP_HEAD : r < 95 ? OP_REMOVE : spare_op;
            send_req(op, pick_key());
        end
    endtask

    task automatic drain_responses();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (LIST_DEPTH + 4) @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_list();
        test_fill_and_overflow();
        test_search_and_remove();
        test_random_traffic(1100, 1'b1);
        test_random_traffic(250, 1'b0);
        drain_responses();
        $display("%0d requests sent, %0d responses checked, %0d mismatches",
                 n_sent, n_checked, err_cnt);
        $display("list was left full %0d times and empty %0d times", full_hits, empty_hits);
        if (err_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
